/* design/strs_pkg.sv */
// ----------------------------------------------------------------------------
// Range sum block package
// Sizes and the control state encoding shared by the range sum block files.
// ----------------------------------------------------------------------------
package strs_pkg;

  localparam int MaxElements = 1024;
  localparam int IdxW        = $clog2(MaxElements);
  localparam int CountW      = IdxW + 1;
  localparam int ValW        = 32;
  localparam int SumW        = 42;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_BUILD = 5'b00010,
    ST_QHI   = 5'b00100,
    ST_QLO   = 5'b01000,
    ST_QSUM  = 5'b10000
  } state_t;

endpackage

/* design/segment_tree_range_sum.sv */
// ----------------------------------------------------------------------------
// Range sum over a loaded array
// Loads signed elements, builds a table of running sums and answers
// inclusive range sum queries from it.
// ----------------------------------------------------------------------------
// Usage: the input channel carries load and query beats. A load beat writes
// one element. A load beat flagged as last starts a build that walks the
// element memory once (count saturated at 1024); no input beat is taken
// meanwhile. A query beat reads two running sums from the sum memory through
// its single read port and subtracts them; no new beat is taken until its
// result has gone to the output register.
// Results are held in an output register; a new beat is accepted while an
// earlier result still waits, but the next query result waits until the
// receiver takes the previous one.
// The configuration channel writes element_count at any time the block is
// idle; a build latches it. Reset clears control state: count 1, no tree, so
// queries return 0 until the first build. Memories are not cleared.
// ----------------------------------------------------------------------------
module segment_tree_range_sum (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic [strs_pkg::IdxW-1:0]           in_element_index,
  input  logic signed [strs_pkg::ValW-1:0]    in_element_value,
  input  logic                                in_last_load,
  input  logic [strs_pkg::IdxW-1:0]           in_query_low,
  input  logic [strs_pkg::IdxW-1:0]           in_query_high,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [strs_pkg::SumW-1:0]    out_range_sum,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [strs_pkg::CountW-1:0]         cfg_element_count
);
  import strs_pkg::*;

  logic signed [ValW-1:0] elem_mem [MaxElements];
  logic signed [SumW-1:0] pre_mem  [MaxElements];

  state_t                 state_r, state_nxt;
  logic [CountW-1:0]      count_r, built_r, built_nxt;
  logic [CountW-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic [IdxW-1:0]        wr_cnt_r, wr_cnt_nxt;
  logic                   rd_v_r, rd_v_nxt;
  logic signed [SumW-1:0] acc_r, acc_nxt;
  logic signed [ValW-1:0] elem_q_r;
  logic signed [SumW-1:0] pre_q_r, phi_r, phi_nxt;
  logic [IdxW-1:0]        lo_r, hi_r, lo_nxt, hi_nxt, pre_addr;
  logic                   empty_r, empty_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [SumW-1:0] sum_r, sum_nxt;
  logic                   in_acc, pre_we;
  logic [CountW-1:0]      sat_count, hi_eff;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_acc        = in_valid && in_ready;
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_range_sum = sum_r;

  assign sat_count = (count_r > CountW'(MaxElements)) ? CountW'(MaxElements) : count_r;
  assign hi_eff    = ({1'b0, in_query_high} < built_r) ? {1'b0, in_query_high}
                                                       : built_r - CountW'(1);
  assign pre_we    = (state_r == ST_BUILD) && rd_v_r;

  // The low running sum stays addressed while the result waits for room.
  always_comb begin
    case (state_r)
      ST_QHI:          pre_addr = hi_r;
      ST_QLO, ST_QSUM: pre_addr = lo_r - IdxW'(1);
      default:         pre_addr = wr_cnt_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    built_nxt     = built_r;
    rd_cnt_nxt    = rd_cnt_r;
    wr_cnt_nxt    = wr_cnt_r;
    rd_v_nxt      = 1'b0;
    acc_nxt       = acc_r;
    phi_nxt       = phi_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sum_nxt       = sum_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_LOAD) begin
            if (in_last_load) begin
              built_nxt  = sat_count;
              rd_cnt_nxt = '0;
              wr_cnt_nxt = '0;
              acc_nxt    = '0;
              if (sat_count != '0) state_nxt = ST_BUILD;
            end
          end else begin
            lo_nxt    = in_query_low;
            hi_nxt    = hi_eff[IdxW-1:0];
            empty_nxt = (built_r == '0) || ({1'b0, in_query_low} > hi_eff);
            state_nxt = ST_QHI;
          end
        end
      end
      ST_BUILD: begin
        // Each running sum is written in the cycle after its element read.
        if (rd_cnt_r < built_r) begin
          rd_cnt_nxt = rd_cnt_r + CountW'(1);
          rd_v_nxt   = 1'b1;
        end
        if (rd_v_r) begin
          acc_nxt    = acc_r + SumW'(elem_q_r);
          wr_cnt_nxt = wr_cnt_r + IdxW'(1);
          if (wr_cnt_r == IdxW'(built_r - CountW'(1))) state_nxt = ST_IDLE;
        end
      end
      ST_QHI: state_nxt = ST_QLO;
      ST_QLO: begin
        phi_nxt   = pre_q_r;
        state_nxt = ST_QSUM;
      end
      ST_QSUM: begin
        if (!out_valid_r || out_ready) begin
          if (empty_r)            sum_nxt = '0;
          else if (lo_r == '0)    sum_nxt = phi_r;
          else                    sum_nxt = phi_r - pre_q_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_operation == OP_LOAD)) begin
      elem_mem[in_element_index] <= in_element_value;
    end
    elem_q_r <= elem_mem[rd_cnt_r[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pre_we) begin
      pre_mem[wr_cnt_r] <= acc_nxt;
    end
    pre_q_r <= pre_mem[pre_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= CountW'(1);
      built_r     <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      built_r     <= built_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) count_r <= cfg_element_count;
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt_r <= rd_cnt_nxt;
    wr_cnt_r <= wr_cnt_nxt;
    acc_r    <= acc_nxt;
    phi_r    <= phi_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    empty_r  <= empty_nxt;
    sum_r    <= sum_nxt;
  end

endmodule

/* design/strs_checker.sv */
// ----------------------------------------------------------------------------
// Range sum port checker
// Watches the top level ports for timing properties of the block.
// ----------------------------------------------------------------------------
module strs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_operation,
  input logic                             in_last_load,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [strs_pkg::SumW-1:0] out_range_sum,
  input logic                             cfg_ready
);
  import strs_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_range_sum))
    else $error("result beat changed while stalled");

  // A query keeps the input channel from taking beats while it runs.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_QUERY) |=> !in_ready ##1 !in_ready)
    else $error("input taken during a query");

  // A plain load never stalls the next beat.
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_LOAD) && !in_last_load |=> in_ready)
    else $error("plain load stalled the input");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind segment_tree_range_sum strs_checker u_strs_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_operation(in_operation), .in_last_load(in_last_load),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_range_sum(out_range_sum), .cfg_ready(cfg_ready)
);

/* bench/tb_segment_tree_range_sum.sv */
// ----------------------------------------------------------------------------
// Range sum block testbench
// Loads element arrays of several sizes, builds the tree and checks every
// range sum query against a scoreboard that sums the elements it saw at build.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_segment_tree_range_sum;
  import strs_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = MaxElements + 16;

  class RangeSumScoreboard;
    logic signed [ValW-1:0] elems[MaxElements];
    logic signed [ValW-1:0] tree_elems[MaxElements];
    int                     element_count = 1;
    int                     built_count = 0;
    logic signed [SumW-1:0] expected_sums[$];
    int                     errors = 0;

    function void set_count(int v);
      element_count = v;
    endfunction

    // Queries see the elements as they stood at the last build, so the
    // build takes a snapshot of the store.
    function void note_beat(logic op, logic [IdxW-1:0] idx, logic signed [ValW-1:0] val,
                            logic last, logic [IdxW-1:0] lo, logic [IdxW-1:0] hi);
      logic signed [SumW-1:0] acc;
      int                     top;
      if (op == OP_LOAD) begin
        elems[idx] = val;
        if (last) begin
          built_count = (element_count > MaxElements) ? MaxElements : element_count;
          for (int i = 0; i < built_count; i++) tree_elems[i] = elems[i];
        end
      end else begin
        acc = '0;
        top = (int'(hi) > built_count - 1) ? built_count - 1 : int'(hi);
        for (int i = int'(lo); i <= top; i++) acc += tree_elems[i];
        expected_sums = {expected_sums, acc};
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_sum(logic signed [SumW-1:0] got);
      logic signed [SumW-1:0] want;
      if (expected_sums.size() == 0) begin
        report($sformatf("range sum %0d with no query waiting", got));
      end else begin
        want = expected_sums.pop_front();
        if (got !== want) report($sformatf("range sum %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_operation = OP_LOAD;
  logic [IdxW-1:0]        in_element_index = '0;
  logic signed [ValW-1:0] in_element_value = '0;
  logic                   in_last_load = 1'b0;
  logic [IdxW-1:0]        in_query_low = '0;
  logic [IdxW-1:0]        in_query_high = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [SumW-1:0] out_range_sum;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CountW-1:0]      cfg_element_count = '0;

  RangeSumScoreboard sb = new();
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int cycles = 0;

  segment_tree_range_sum dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_element_index(in_element_index), .in_element_value(in_element_value),
    .in_last_load(in_last_load), .in_query_low(in_query_low),
    .in_query_high(in_query_high),
    .out_valid(out_valid), .out_ready(out_ready), .out_range_sum(out_range_sum),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_element_count(cfg_element_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_ready)
      sb.note_beat(in_operation, in_element_index, in_element_value, in_last_load,
                   in_query_low, in_query_high);
    if (out_valid && out_ready) sb.check_sum(out_range_sum);
  end

  // Receiver: random stalls, plus one long hold when asked for.
  initial begin
    int hold_cycles;
    hold_cycles = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cycles = 300;
      end
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
      end
    end
  end

  task send_beat(logic op, logic [IdxW-1:0] idx, logic signed [ValW-1:0] val, logic last,
                 logic [IdxW-1:0] lo, logic [IdxW-1:0] hi);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_element_index <= idx;
    in_element_value <= val;
    in_last_load     <= last;
    in_query_low     <= lo;
    in_query_high    <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task send_load(logic [IdxW-1:0] idx, logic signed [ValW-1:0] val, logic last);
    send_beat(OP_LOAD, idx, val, last, IdxW'($urandom), IdxW'($urandom));
  endtask

  task send_query(logic [IdxW-1:0] lo, logic [IdxW-1:0] hi);
    send_beat(OP_QUERY, IdxW'($urandom), $urandom, 1'($urandom), lo, hi);
  endtask

  task send_random_query(int n);
    int span;
    span = (n > MaxElements) ? MaxElements : ((n < 1) ? 1 : n);
    if ($urandom_range(3) == 0)
      send_query(IdxW'($urandom), IdxW'($urandom));
    else
      send_query(IdxW'($urandom_range(span - 1)), IdxW'($urandom_range(span + 2, 0)));
  endtask

  // Let every result come back and any build finish before touching config.
  task drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_sums.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task write_count(int v);
    cfg_valid         <= 1'b1;
    cfg_element_count <= CountW'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_count(v);
    cfg_valid <= 1'b0;
  endtask

  // Fill mode 0 is random, 1 the largest value, 2 the smallest.
  task load_array(int n, int fill);
    int                     stored;
    logic signed [ValW-1:0] v;
    stored = (n > MaxElements) ? MaxElements : n;
    for (int i = 0; i < stored; i++) begin
      v = (fill == 1) ? 32'sh7fffffff : (fill == 2) ? 32'sh80000000 : $urandom;
      send_load(IdxW'(i), v, i == stored - 1);
    end
    if (stored == 0) send_load(IdxW'($urandom), $urandom, 1'b1);
  endtask

  task run_phase(int n, int fill, int queries);
    drain();
    write_count(n);
    load_array(n, fill);
    send_query('0, IdxW'(MaxElements - 1));
    for (int q = 0; q < queries; q++) begin
      case ($urandom_range(19))
        0, 1, 2: send_load(IdxW'($urandom), $urandom, 1'b0);
        3: send_load(IdxW'($urandom), $urandom, 1'b1);
        default: send_random_query(n);
      endcase
    end
  endtask

  initial begin
    int counts[8];
    int fills[8];
    counts = '{2047, 0, 1, 2, 17, 24, 33, 9};
    fills  = '{1, 0, 0, 0, 0, 0, 2, 0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Queries before any build see an empty tree.
    send_query('0, IdxW'(MaxElements - 1));
    send_query('0, '0);
    drain();
    write_count(5);
    send_load(IdxW'(0), 32'sh7fffffff, 1'b0);
    send_load(IdxW'(1), 32'sh80000000, 1'b0);
    send_load(IdxW'(2), -1, 1'b0);
    send_load(IdxW'(3), 0, 1'b0);
    send_load(IdxW'(4), 1, 1'b1);
    send_load(IdxW'(MaxElements - 1), 32'sh7fffffff, 1'b0);
    send_query(IdxW'(0), IdxW'(4));
    send_query(IdxW'(0), IdxW'(MaxElements - 1));
    send_query(IdxW'(3), IdxW'(1));
    send_query(IdxW'(2), IdxW'(2));
    send_query(IdxW'(MaxElements - 1), IdxW'(MaxElements - 1));
    send_query(IdxW'(0), IdxW'(0));
    send_query(IdxW'(4), IdxW'(9));
    // A new count stays unused until the next build.
    drain();
    write_count(3);
    send_query(IdxW'(0), IdxW'(4));
    send_query(IdxW'(1), IdxW'(MaxElements - 1));

    for (int p = 0; p < 8; p++) begin
      calm = (p == 5);
      if (p == 4) begin
        drain();
        hold_request = 1'b1;
        for (int q = 0; q < 40; q++) send_query(IdxW'(0), IdxW'($urandom_range(4)));
      end
      run_phase(counts[p], fills[p], (p == 0) ? 20 : ((p == 5) ? 60 : 30));
    end
    calm = 1'b0;

    drain();
    if (sb.expected_sums.size() != 0) sb.report("queries left without a result");
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
